### src/vwap_pkg.sv
// ----------------------------------------------------------------------------
// vwap_pkg
// Shared widths, status codes and the queue entry type of the volume-weighted
// average price accumulator.
// ----------------------------------------------------------------------------
package vwap_pkg;

	localparam int PRICE_W  = 24;
	localparam int QTY_W    = 24;
	localparam int PROD_W   = PRICE_W + QTY_W;
	localparam int WSUM_W   = 64;
	localparam int AVG_W    = 39;
	localparam int STATUS_W = 2;
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	// One classified trade as it travels from the front to the back.
	typedef struct packed {
		logic [PROD_W-1:0] prod;
		logic [QTY_W-1:0]  qty;
		logic              invalid;
		logic              last;
	} item_t;

endpackage

### src/vwap_front.sv
// ----------------------------------------------------------------------------
// vwap_front
// Accepts trade requests, checks price and quantity, and registers the
// price-quantity product for the back end.
// ----------------------------------------------------------------------------
module vwap_front #(
	parameter int PRICE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [vwap_pkg::PRICE_W-1:0]  price,
	input  logic [vwap_pkg::QTY_W-1:0]    quantity,
	input  logic                          s_tlast,
	output logic                          item_valid,
	input  logic                          item_ready,
	output vwap_pkg::item_t               item
);
	import vwap_pkg::*;

	// Price bits that take part; a field narrower than PRICE_BITS has no sign.
	localparam int PB = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
	localparam bit HAS_SIGN = (PRICE_BITS <= PRICE_W);

	logic [PRICE_W-1:0] price_mask;
	logic [PRICE_W-1:0] price_m;
	logic               neg;
	logic               valid_s1;
	item_t              item_s1;
	logic               take;

	assign price_mask = {PRICE_W{1'b1}} >> (PRICE_W - PB);
	assign price_m    = price & price_mask;
	assign neg        = HAS_SIGN & price[PB-1];

	assign s_tready = !valid_s1 || item_ready;
	assign take     = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (item_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.prod    <= PROD_W'(price_m) * PROD_W'(quantity);
			item_s1.qty     <= quantity;
			item_s1.invalid <= neg || (price_m == '0) || (quantity == '0);
			item_s1.last    <= s_tlast;
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

### src/vwap_fifo.sv
// ----------------------------------------------------------------------------
// vwap_fifo
// Short queue of classified trades between the front and the back end.
// ----------------------------------------------------------------------------
module vwap_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  vwap_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output vwap_pkg::item_t out_item
);
	import vwap_pkg::*;

	item_t             mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = cnt_q != (QPTR_W+1)'(QDEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= in_item;
		end
	end

endmodule

### src/vwap_div.sv
// ----------------------------------------------------------------------------
// vwap_div
// Restoring divider: (num << FRAC_BITS) / den, one quotient bit per cycle,
// saturated to the average width.
// ----------------------------------------------------------------------------
module vwap_div #(
	parameter int FRAC_BITS    = 16,
	parameter int QTY_SUM_BITS = 40
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vwap_pkg::WSUM_W-1:0]  num,
	input  logic [QTY_SUM_BITS-1:0]      den,
	output logic                         done,
	output logic [vwap_pkg::AVG_W-1:0]   quot
);
	import vwap_pkg::*;

	localparam int NW    = WSUM_W + FRAC_BITS;
	localparam int HI_W  = NW - AVG_W;
	localparam int CMP_W = (HI_W > QTY_SUM_BITS) ? HI_W : QTY_SUM_BITS;
	localparam int CNT_W = $clog2(AVG_W + 1);

	logic [NW-1:0]           n_full;
	logic [HI_W-1:0]         n_hi;
	logic [CMP_W-1:0]        n_hi_w;
	logic                    sat;
	logic [QTY_SUM_BITS-1:0] den_q;
	logic [QTY_SUM_BITS-1:0] rem_q;
	logic [AVG_W-1:0]        sh_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q;
	logic                    done_q;
	logic [QTY_SUM_BITS:0]   r2;
	logic [QTY_SUM_BITS:0]   r2_sub;
	logic                    ge;

	assign n_full = NW'(num) << FRAC_BITS;
	assign n_hi   = n_full[NW-1:AVG_W];
	assign n_hi_w = CMP_W'(n_hi);
	// The quotient fits only if the upper part of the dividend is below den.
	assign sat    = n_hi_w >= CMP_W'(den);

	assign r2     = {rem_q, sh_q[AVG_W-1]};
	assign r2_sub = r2 - {1'b0, den_q};
	assign ge     = r2 >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !sat;
			done_q <= sat;
			cnt_q  <= CNT_W'(AVG_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= n_hi_w[QTY_SUM_BITS-1:0] & {QTY_SUM_BITS{!sat}};
			sh_q  <= sat ? {AVG_W{1'b1}} : n_full[AVG_W-1:0];
		end else if (busy_q) begin
			rem_q <= ge ? r2_sub[QTY_SUM_BITS-1:0] : r2[QTY_SUM_BITS-1:0];
			sh_q  <= {sh_q[AVG_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = sh_q;

endmodule

### src/vwap_back.sv
// ----------------------------------------------------------------------------
// vwap_back
// Accumulates weighted and quantity sums with sticky status, divides at the
// end of a run and holds the result in the output register.
// ----------------------------------------------------------------------------
module vwap_back #(
	parameter int FRAC_BITS    = 16,
	parameter int QTY_SUM_BITS = 40
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  vwap_pkg::item_t                item,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [vwap_pkg::AVG_W-1:0]     average_price,
	output logic [vwap_pkg::STATUS_W-1:0]  status
);
	import vwap_pkg::*;

	localparam logic [1:0] S_ACC   = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;

	logic [1:0]              state_q;
	logic [WSUM_W-1:0]       ws_q;
	logic [QTY_SUM_BITS-1:0] qs_q;
	logic [STATUS_W-1:0]     run_q;
	logic                    valid_q;
	logic [AVG_W-1:0]        avg_q;
	logic [STATUS_W-1:0]     status_q;
	logic [WSUM_W:0]         ws_add;
	logic [QTY_SUM_BITS:0]   qs_add;
	logic                    pop;
	logic                    out_free;
	logic                    run_bad;
	logic                    div_start;
	logic                    div_done;
	logic [AVG_W-1:0]        div_quot;
	logic                    emit_bad;
	logic                    emit_div;

	assign ws_add     = {1'b0, ws_q} + (WSUM_W+1)'(item.prod);
	assign qs_add     = {1'b0, qs_q} + (QTY_SUM_BITS+1)'(item.qty);
	assign item_ready = state_q == S_ACC;
	assign pop        = item_valid && item_ready;
	assign out_free   = !valid_q || m_tready;
	assign run_bad    = (run_q != ST_OK) || (qs_q == '0);
	assign div_start  = (state_q == S_CHECK) && !run_bad;
	assign emit_bad   = (state_q == S_CHECK) && run_bad && out_free;
	assign emit_div   = (state_q == S_DIV) && div_done && out_free;

	vwap_div #(
		.FRAC_BITS    (FRAC_BITS),
		.QTY_SUM_BITS (QTY_SUM_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (ws_q),
		.den    (qs_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			ws_q    <= '0;
			qs_q    <= '0;
			run_q   <= ST_OK;
			valid_q <= 1'b0;
		end else begin
			if (emit_bad || emit_div) begin
				valid_q <= 1'b1;
			end else if (valid_q && m_tready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				S_ACC: begin
					if (pop) begin
						if (run_q == ST_OK) begin
							if (item.invalid) begin
								run_q <= ST_INVALID;
							end else if (ws_add[WSUM_W] || qs_add[QTY_SUM_BITS]) begin
								run_q <= ST_OVERFLOW;
							end else begin
								ws_q <= ws_add[WSUM_W-1:0];
								qs_q <= qs_add[QTY_SUM_BITS-1:0];
							end
						end
						if (item.last) begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (!run_bad) begin
						state_q <= S_DIV;
					end else if (out_free) begin
						ws_q    <= '0;
						qs_q    <= '0;
						run_q   <= ST_OK;
						state_q <= S_ACC;
					end
				end
				S_DIV: begin
					if (div_done && out_free) begin
						ws_q    <= '0;
						qs_q    <= '0;
						run_q   <= ST_OK;
						state_q <= S_ACC;
					end
				end
				default: begin
					state_q <= S_ACC;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit_bad) begin
			avg_q    <= '0;
			status_q <= (run_q != ST_OK) ? run_q : ST_INVALID;
		end else if (emit_div) begin
			avg_q    <= div_quot;
			status_q <= ST_OK;
		end
	end

	assign m_tvalid      = valid_q;
	assign average_price = avg_q;
	assign status        = status_q;

endmodule

### src/vwap_accumulator.sv
// ----------------------------------------------------------------------------
// vwap_accumulator
// Volume-weighted average price over runs of trades, with sticky status.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  s_*       in         one trade: price, quantity, tlast marks the run end
//  m_*       out        one result per run: average price, status in tuser
//
// The front takes one trade request per cycle while its stage register can
// move on; the multiply sits in its stage register and a four-entry queue
// feeds the back end. The back end accumulates one trade per cycle in its
// accumulate state. After the last trade of a run it passes through a check
// state, the bit-serial divider and the load of the output register, which
// waits for a free output. A run with a bad status reports from its check state.
// While the divider runs, the queue keeps taking trades until it fills.
// Reset clears the sums, the status, the queue and the output valid.
module vwap_accumulator #(
	parameter int FRAC_BITS    = 16,
	parameter int PRICE_BITS   = 24,
	parameter int QTY_SUM_BITS = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [23:0] price, [47:24] quantity
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [38:0] average_price, [39] zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import vwap_pkg::*;

	item_t            front_item;
	logic             front_valid;
	logic             front_ready;
	item_t            queue_item;
	logic             queue_valid;
	logic             queue_ready;
	logic [AVG_W-1:0] avg;

	vwap_front #(
		.PRICE_BITS (PRICE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.price      (s_tdata[PRICE_W-1:0]),
		.quantity   (s_tdata[PRICE_W+QTY_W-1:PRICE_W]),
		.s_tlast    (s_tlast),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	vwap_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (queue_valid),
		.out_ready (queue_ready),
		.out_item  (queue_item)
	);

	vwap_back #(
		.FRAC_BITS    (FRAC_BITS),
		.QTY_SUM_BITS (QTY_SUM_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (queue_valid),
		.item_ready    (queue_ready),
		.item          (queue_item),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.average_price (avg),
		.status        (m_tuser)
	);

	assign m_tdata = {1'b0, avg};

endmodule

### src/vwap_checker.sv
// ----------------------------------------------------------------------------
// vwap_checker
// Port-level checks of the accumulator's result channel.
// ----------------------------------------------------------------------------
module vwap_props (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// The output valid must be low while reset is held.
	assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result valid during reset");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == 2'd0 || m_tuser == 2'd1 || m_tuser == 2'd2))
		else $error("undefined status code");

	// A failed run reports a zero price.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != 2'd0) |-> (m_tdata == 40'd0))
		else $error("nonzero price with bad status");

	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind vwap_accumulator vwap_props u_chk (.*);
